@@ src/textured_column_span_renderer_assert.svh @@
// Assertion macros for the textured column span renderer.
// Included by the top level; no other dependencies.
`ifndef TEXTURED_COLUMN_SPAN_RENDERER_ASSERT_SVH
`define TEXTURED_COLUMN_SPAN_RENDERER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define TCSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define TCSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCSR_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define TCSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ src/tcsr_pkg.sv @@
// Shared constants, codes and types of the textured column span renderer.
// No dependencies; the registers, controller, datapath and top level import this package.
`default_nettype none

package tcsr_pkg;

  // Texture store and fixed-point format.
  localparam int TEX_WORDS = 4096;
  localparam int ADDR_W    = $clog2(TEX_WORDS);
  localparam int FRAC_BITS = 16;
  localparam int TH_W      = 7;
  // Dividend and quotient width of the step division.
  localparam int DIVW      = TH_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(DIVW);
  // Position format and start-position product.
  localparam int POS_W     = 40;
  localparam int HI_W      = POS_W - 1 - FRAC_BITS;
  localparam int BASE_W    = 18;
  localparam int PROD_W    = BASE_W + DIVW + 1;
  localparam int EXT_W     = (PROD_W > POS_W) ? PROD_W : POS_W + 1;

  // Item opcodes.
  localparam logic [1:0] OP_TEXEL = 2'd0;
  localparam logic [1:0] OP_SETUP = 2'd1;
  localparam logic [1:0] OP_ROW   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Draw modes.
  localparam logic [1:0] MODE_WALL   = 2'd0;
  localparam logic [1:0] MODE_DOOR   = 2'd1;
  localparam logic [1:0] MODE_SPRITE = 2'd2;
  localparam logic [1:0] MODE_OFF    = 2'd3;

  // Register indexes.
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd0;
  localparam logic [2:0] REG_TEX_WIDTH     = 3'd1;
  localparam logic [2:0] REG_TEX_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_CEILING_COLOR = 3'd3;
  localparam logic [2:0] REG_FLOOR_COLOR   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEXW,
    ST_DIV,
    ST_MUL,
    ST_START,
    ST_ROW_ADDR,
    ST_ROW_PIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [11:0] screen_height;
    logic [6:0]  tex_width;
    logic [6:0]  tex_height;
    logic [31:0] ceiling_color;
    logic [31:0] floor_color;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] texel_index;
    logic [31:0] texel_color;
    logic [11:0] span_start;
    logic [11:0] span_end;
    logic [15:0] proj_height;
    logic [5:0]  tex_column;
    logic [1:0]  draw_mode;
    logic [10:0] row;
  } in_item_t;

  typedef struct packed {
    logic        write_pixel;
    logic        layer;
    logic [31:0] pixel_color;
    logic [10:0] pixel_row;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic tex_write;
    logic div_step;
    logic mul;
    logic set_start;
    logic row_addr;
    logic row_pix;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ src/tcsr_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
// No dependencies.
`default_nettype none

interface tcsr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [11:0] texel_index;
  logic [31:0] texel_color;
  logic [11:0] span_start;
  logic [11:0] span_end;
  logic [15:0] proj_height;
  logic [5:0]  tex_column;
  logic [1:0]  draw_mode;
  logic [10:0] row;

  modport source (
    output valid, op, texel_index, texel_color, span_start, span_end,
           proj_height, tex_column, draw_mode, row,
    input  ready
  );
  modport sink (
    input  valid, op, texel_index, texel_color, span_start, span_end,
           proj_height, tex_column, draw_mode, row,
    output ready
  );
endinterface

interface tcsr_out_if;
  logic        valid;
  logic        ready;
  logic        write_pixel;
  logic        layer;
  logic [31:0] pixel_color;
  logic [10:0] pixel_row;

  modport source (
    output valid, write_pixel, layer, pixel_color, pixel_row,
    input  ready
  );
  modport sink (
    input  valid, write_pixel, layer, pixel_color, pixel_row,
    output ready
  );
endinterface

`default_nettype wire

@@ src/tcsr_regs.sv @@
// APB configuration registers of the renderer.
// Depends on tcsr_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module tcsr_regs
  import tcsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_height <= 12'd1024;
      cfg.tex_width     <= 7'd64;
      cfg.tex_height    <= 7'd64;
      cfg.ceiling_color <= '0;
      cfg.floor_color   <= '0;
    end else if (wr_en) begin
      unique case (index)
        REG_SCREEN_HEIGHT: cfg.screen_height <= pwdata[11:0];
        REG_TEX_WIDTH:     cfg.tex_width     <= pwdata[6:0];
        REG_TEX_HEIGHT:    cfg.tex_height    <= pwdata[6:0];
        REG_CEILING_COLOR: cfg.ceiling_color <= pwdata;
        REG_FLOOR_COLOR:   cfg.floor_color   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (index)
      REG_SCREEN_HEIGHT: prdata = {20'd0, cfg.screen_height};
      REG_TEX_WIDTH:     prdata = {25'd0, cfg.tex_width};
      REG_TEX_HEIGHT:    prdata = {25'd0, cfg.tex_height};
      REG_CEILING_COLOR: prdata = cfg.ceiling_color;
      REG_FLOOR_COLOR:   prdata = cfg.floor_color;
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/tcsr_ctrl.sv @@
// Controller state machine of the renderer: sequences one item at a time.
// Depends on tcsr_pkg for state_t, cmd_t, stat_t and the opcodes.
`default_nettype none

module tcsr_ctrl
  import tcsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  input  stat_t      stat,
  output logic       in_ready,
  output cmd_t       cmd,
  output state_t     state
);

  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_TEXEL: state_next = ST_TEXW;
            OP_SETUP: state_next = ST_DIV;
            OP_ROW:   state_next = ST_ROW_ADDR;
            OP_NONE:  state_next = ST_DONE;
          endcase
        end
      end
      ST_TEXW:     state_next = ST_DONE;
      ST_DIV:      state_next = stat.div_last ? ST_MUL : ST_DIV;
      ST_MUL:      state_next = ST_START;
      ST_START:    state_next = ST_DONE;
      ST_ROW_ADDR: state_next = ST_ROW_PIX;
      ST_ROW_PIX:  state_next = ST_DONE;
      ST_DONE:     state_next = stat.out_free ? ST_IDLE : ST_DONE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd           = '0;
    cmd.capture   = (state == ST_IDLE) && in_valid;
    cmd.tex_write = (state == ST_TEXW);
    cmd.div_step  = (state == ST_DIV);
    cmd.mul       = (state == ST_MUL);
    cmd.set_start = (state == ST_START);
    cmd.row_addr  = (state == ST_ROW_ADDR);
    cmd.row_pix   = (state == ST_ROW_PIX);
    cmd.load_out  = (state == ST_DONE) && stat.out_free;
  end

endmodule

`default_nettype wire

@@ src/tcsr_dp.sv @@
// Datapath of the renderer: texture memory, step divider, start multiplier,
// column state, row pixel logic and the output register. Depends on tcsr_pkg.
`default_nettype none

module tcsr_dp
  import tcsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  input  logic      out_ready,
  output stat_t     stat,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic signed [EXT_W-1:0] POS_MAX_X =
    {{(EXT_W - POS_W + 1){1'b0}}, {(POS_W - 1){1'b1}}};
  localparam logic signed [EXT_W-1:0] POS_MIN_X = ~POS_MAX_X;
  localparam logic signed [POS_W-1:0] POS_MAX   = {1'b0, {(POS_W - 1){1'b1}}};

  // Captured item and column state.
  in_item_t                 in_q;
  logic [11:0]              span_first;
  logic [11:0]              span_last;
  logic [1:0]               column_mode;
  logic [5:0]               column_texel;
  logic [DIVW-1:0]          step_q;
  logic signed [POS_W-1:0]  pos_q;

  // Divider state.
  logic [DIVW-1:0]          quo_sh;
  logic [15:0]              rem_q;
  logic [CNT_W-1:0]         cnt_q;

  // Start-position product.
  logic signed [PROD_W-1:0] prod_q;

  // Row pipeline.
  logic [31:0]              mem [TEX_WORDS];
  logic [31:0]              rdata_q;
  logic                     inside_q;
  logic                     floor_q;
  logic                     ceil_q;
  out_item_t                res_q;

  // Effective texture size, line height and start base.
  logic [6:0]               tw_eff;
  logic [6:0]               th_eff;
  logic [6:0]               tw_m1;
  logic [6:0]               th_m1;
  logic [15:0]              lh_eff;
  logic signed [BASE_W-1:0] base;

  assign tw_eff = (cfg.tex_width == 7'd0) ? 7'd1 : cfg.tex_width;
  assign th_eff = (cfg.tex_height == 7'd0) ? 7'd1 : cfg.tex_height;
  assign tw_m1  = tw_eff - 7'd1;
  assign th_m1  = th_eff - 7'd1;
  assign lh_eff = (in_q.proj_height == 16'd0) ? 16'd1 : in_q.proj_height;
  assign base   = $signed({6'd0, in_q.span_start})
                - $signed({7'd0, cfg.screen_height[11:1]})
                + $signed({3'd0, in_q.proj_height[15:1]});

  // One restoring division step.
  logic [16:0] rem_sh;
  logic [16:0] rem_diff;
  logic        rem_ge;

  assign rem_sh   = {rem_q, quo_sh[DIVW-1]};
  assign rem_diff = rem_sh - {1'b0, lh_eff};
  assign rem_ge   = (rem_sh >= {1'b0, lh_eff});

  assign stat.div_last = (cnt_q == CNT_W'(DIVW - 1));
  assign stat.out_free = !out_valid || out_ready;

  // Saturated start position from the product.
  logic signed [EXT_W-1:0] prod_x;
  logic signed [POS_W-1:0] start_pos;

  always_comb begin
    prod_x = EXT_W'(prod_q);
    if (prod_x > POS_MAX_X) begin
      start_pos = POS_MAX;
    end else if (prod_x < POS_MIN_X) begin
      start_pos = ~POS_MAX;
    end else begin
      start_pos = prod_x[POS_W-1:0];
    end
  end

  // Position advance, saturating at the positive limit.
  logic [POS_W:0]          pos_sum;
  logic signed [POS_W-1:0] pos_adv;

  assign pos_sum = {pos_q[POS_W-1], pos_q} + (POS_W + 1)'(step_q);
  assign pos_adv = (pos_sum[POS_W] != pos_sum[POS_W-1]) ? POS_MAX : pos_sum[POS_W-1:0];

  // Texel address: clamped texture row and column.
  logic [HI_W-1:0]   pos_hi;
  logic [5:0]        tex_row;
  logic [5:0]        tex_col;
  logic [12:0]       addr_full;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  always_comb begin
    pos_hi = pos_q[POS_W-2:FRAC_BITS];
    if (pos_q[POS_W-1]) begin
      tex_row = 6'd0;
    end else if (pos_hi > HI_W'(th_m1)) begin
      tex_row = th_m1[5:0];
    end else begin
      tex_row = pos_hi[5:0];
    end
    tex_col   = ({1'b0, column_texel} > tw_m1) ? tw_m1[5:0] : column_texel;
    addr_full = 13'(tw_eff) * 13'(tex_row) + 13'(tex_col);
    rd_addr   = ADDR_W'(addr_full);
    wr_addr   = ADDR_W'(in_q.texel_index);
  end

  // Row classification.
  logic [11:0] row_x;
  logic        in_screen;
  logic        is_wall;

  assign row_x     = {1'b0, in_q.row};
  assign in_screen = (row_x < cfg.screen_height) && (column_mode != MODE_OFF);
  assign is_wall   = (column_mode == MODE_WALL);

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_q <= in_item;
    end
  end

  // Step divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      quo_sh <= {th_eff, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd.div_step) begin
      quo_sh <= {quo_sh[DIVW-2:0], rem_ge};
      rem_q  <= rem_ge ? rem_diff[15:0] : rem_sh[15:0];
      cnt_q  <= cnt_q + CNT_W'(1);
    end
  end

  // Start-position multiplier.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_q <= base * $signed({1'b0, quo_sh});
    end
  end

  // Column state: latched at setup, position advanced by span rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      span_first   <= '0;
      span_last    <= '0;
      column_mode  <= '0;
      column_texel <= '0;
      step_q       <= '0;
      pos_q        <= '0;
    end else begin
      if (cmd.mul) begin
        step_q <= quo_sh;
      end
      if (cmd.set_start) begin
        span_first   <= in_q.span_start;
        span_last    <= in_q.span_end;
        column_mode  <= in_q.draw_mode;
        column_texel <= in_q.tex_column;
        pos_q        <= (in_q.draw_mode == MODE_SPRITE) ? '0 : start_pos;
      end else if (cmd.row_pix && inside_q) begin
        pos_q <= pos_adv;
      end
    end
  end

  // Texture memory: written by texel items, read for span rows.
  always_ff @(posedge clk) begin
    if (cmd.tex_write) begin
      mem[wr_addr] <= in_q.texel_color;
    end
    if (cmd.row_addr) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Row flags, registered alongside the memory read.
  always_ff @(posedge clk) begin
    if (cmd.row_addr) begin
      inside_q <= in_screen && (row_x >= span_first) && (row_x < span_last);
      floor_q  <= in_screen && is_wall && (row_x >= span_last);
      ceil_q   <= in_screen && is_wall && (row_x < span_first);
    end
  end

  // Result of the current item; non-row items leave it all zero.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_q <= '0;
    end else if (cmd.row_pix) begin
      res_q.pixel_row <= in_q.row;
      res_q.layer     <= (column_mode == MODE_DOOR) || (column_mode == MODE_SPRITE);
      if (inside_q && (is_wall || (rdata_q[7:0] != 8'd0))) begin
        res_q.write_pixel <= 1'b1;
        res_q.pixel_color <= rdata_q;
      end else if (floor_q) begin
        res_q.write_pixel <= 1'b1;
        res_q.pixel_color <= cfg.floor_color;
      end else if (ceil_q) begin
        res_q.write_pixel <= 1'b1;
        res_q.pixel_color <= cfg.ceiling_color;
      end else begin
        res_q.write_pixel <= 1'b0;
        res_q.pixel_color <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item <= res_q;
    end
  end

endmodule

`default_nettype wire

@@ src/textured_column_span_renderer.sv @@
// Textured column span renderer, top level: one screen column of a raycaster.
// Depends on tcsr_pkg, tcsr_if, tcsr_regs, tcsr_ctrl, tcsr_dp and the assert header.
// Items are handled one at a time and each yields one result transfer. A texel
// write passes through a write state, a screen row through the address stage and
// the registered read of the texture memory, and a column setup through the step
// divider that makes one of its 23 quotient bits per cycle, then a multiply and a
// saturate step. A finished result sits in the output register while the next
// item is taken in. Configure through the APB port only while no item is in
// flight; the texture memory has no reset and a row must only sample texels that
// were written.
`default_nettype none
`include "textured_column_span_renderer_assert.svh"

module textured_column_span_renderer
  import tcsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tcsr_in_if.sink     in_ch,
  tcsr_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  cmd_t      cmd;
  stat_t     stat;
  state_t    state;
  in_item_t  in_item;
  out_item_t out_item;
  logic      in_ready;
  logic      out_valid;

  // Input payload bundle.
  assign in_item.op          = in_ch.op;
  assign in_item.texel_index = in_ch.texel_index;
  assign in_item.texel_color = in_ch.texel_color;
  assign in_item.span_start  = in_ch.span_start;
  assign in_item.span_end    = in_ch.span_end;
  assign in_item.proj_height = in_ch.proj_height;
  assign in_item.tex_column  = in_ch.tex_column;
  assign in_item.draw_mode   = in_ch.draw_mode;
  assign in_item.row         = in_ch.row;
  assign in_ch.ready         = in_ready;

  // Output channel.
  assign out_ch.valid       = out_valid;
  assign out_ch.write_pixel = out_item.write_pixel;
  assign out_ch.layer       = out_item.layer;
  assign out_ch.pixel_color = out_item.pixel_color;
  assign out_ch.pixel_row   = out_item.pixel_row;

  // Configuration registers.
  tcsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Controller.
  tcsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd),
    .state    (state)
  );

  // Datapath.
  tcsr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Only one item is in flight at a time.
  `TCSR_ASSERT_NEXT(a_one_item, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready, "item accepted while busy")
  // A result with no pixel carries a zero color.
  `TCSR_ASSERT_NOW(a_zero_color, clk, rst, out_ch.valid && !out_ch.write_pixel, out_ch.pixel_color == 32'd0, "color set without pixel")
  // The divider hands over to the multiplier after its last step.
  `TCSR_ASSERT_NEXT(a_div_to_mul, clk, rst, cmd.div_step && stat.div_last, cmd.mul && (state == ST_MUL), "divider did not finish")

endmodule

`default_nettype wire
